@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while reset is high
`define RBS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also runs through reset
`define RBS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rbs_pkg.sv @@
`default_nettype none

package rbs_pkg;

   localparam int unsigned RBS_MAX_CAPACITY = 32'd16777216;
   localparam int unsigned FIELD_W          = 25;
   localparam int unsigned MODE_W           = 3;
   localparam int unsigned ACTION_W         = 2;
   localparam int unsigned GRAN_BITS        = 8;
   localparam int unsigned AVG_SHIFT        = 4;
   localparam logic [FIELD_W-1:0] MIN_CAP_RESET = 25'd4096;

   typedef enum logic [MODE_W-1:0] {
      MODE_PREPARE = 3'd0,
      MODE_COMMIT  = 3'd1,
      MODE_CONSUME = 3'd2,
      MODE_DECAY   = 3'd3,
      MODE_CLEAR   = 3'd4,
      MODE_RESET   = 3'd5,
      MODE_OPEN    = 3'd6
   } mode_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE    = 2'd0,
      ACT_COMPACT = 2'd1,
      ACT_GROW    = 2'd2,
      ACT_SHRINK  = 2'd3
   } action_type;

   localparam logic CSR_MIN_CAPACITY     = 1'b0;
   localparam logic CSR_INITIAL_CAPACITY = 1'b1;

   // result tdata layout
   localparam int unsigned RSP_CAP_LSB    = 0;
   localparam int unsigned RSP_READ_LSB   = 25;
   localparam int unsigned RSP_WRITE_LSB  = 50;
   localparam int unsigned RSP_FREE_LSB   = 75;
   localparam int unsigned RSP_MARK_LSB   = 100;
   localparam int unsigned RSP_ACT_LSB    = 125;
   localparam int unsigned RSP_MOVED_LSB  = 127;
   localparam int unsigned RSP_DATA_W     = 152;
   localparam int unsigned REQ_DATA_W     = 32;

endpackage

`default_nettype wire

@@ rtl/receive_buffer_sizing_policy.sv @@
`default_nettype none

// Receive buffer sizing policy: bookkeeping for an adaptive byte receive buffer
// (capacity, read/write cursors, peak demand, averaged usage watermark, traffic
// flag). Each req item is one event (prepare, commit, consume, decay tick, clear,
// reset, open) and yields exactly one rsp item with the state after the event,
// the copy action taken and a rejected flag in rsp_tuser. One event is taken
// every clock cycle unless the output is stalled by rsp_tready; an item lands in
// the input register when accepted, and its result moves into the output
// register once that is free, where rsp_tvalid rises. The rate is set by the
// single pass of event logic between those two registers. Csr writes are always
// accepted and must only be issued while no event is in flight.
module receive_buffer_sizing_policy
   import rbs_pkg::*;
#(
   parameter int unsigned MAX_CAPACITY = RBS_MAX_CAPACITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // mode [2:0], amount [27:3], zero [31:28]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // capacity, read_offset, write_offset, writable_bytes, usage_mark (25 each),
   // copy_action (2), moved_bytes (25)
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rejected
   output logic [0:0]                 rsp_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [FIELD_W-1:0]    csr_data
);

   localparam int unsigned SW = $clog2(MAX_CAPACITY + 1);
   localparam int unsigned EW = ((SW > FIELD_W) ? SW : FIELD_W) + 2;
   localparam int unsigned AW = EW + AVG_SHIFT;
   localparam logic [EW-1:0] MAX_E = EW'(MAX_CAPACITY);

   function automatic logic [EW-1:0] round_gran(input logic [EW-1:0] n);
      logic [EW-1:0] s;
      s = n + EW'((1 << GRAN_BITS) - 1);
      return {s[EW-1:GRAN_BITS], {GRAN_BITS{1'b0}}};
   endfunction

   function automatic logic [EW-1:0] max_e(input logic [EW-1:0] a, input logic [EW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // registers
   logic                 in_valid_ff;
   logic [MODE_W-1:0]    in_mode_ff;
   logic [FIELD_W-1:0]   in_amount_ff;
   logic [SW-1:0]        cap_ff, head_ff, tail_ff, peak_ff, wm_ff;
   logic                 traffic_ff;
   logic [FIELD_W-1:0]   min_cap_ff, init_cap_ff;
   logic                 out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                 out_rej_ff;

   logic advance;

   // extended state
   logic [EW-1:0] e_cap, e_head, e_tail, e_peak, e_wm, e_min, e_init, e_amt;
   logic [EW-1:0] live, room_tail, room_live, live_amt;
   logic [EW-1:0] grow_cap, head_add, tail_add, open_cap, wm_samp;
   logic [EW-1:0] shr_wm, shr_live, shr_tgt;
   logic [AW-1:0] samp_sum;
   logic          drained, grow_over, open_over, shr_ok;

   // next state
   logic [EW-1:0] cap_in, head_in, tail_in, peak_in, wm_in, moved_in, free_in;
   logic          traffic_in, rej_in;
   action_type    act_in;
   mode_type      mode;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_rej_ff;
   assign mode       = mode_type'(in_mode_ff);

   assign e_cap  = {{(EW-SW){1'b0}}, cap_ff};
   assign e_head = {{(EW-SW){1'b0}}, head_ff};
   assign e_tail = {{(EW-SW){1'b0}}, tail_ff};
   assign e_peak = {{(EW-SW){1'b0}}, peak_ff};
   assign e_wm   = {{(EW-SW){1'b0}}, wm_ff};
   assign e_min  = {{(EW-FIELD_W){1'b0}}, min_cap_ff};
   assign e_init = {{(EW-FIELD_W){1'b0}}, init_cap_ff};
   assign e_amt  = {{(EW-FIELD_W){1'b0}}, in_amount_ff};

   assign live      = e_tail - e_head;
   assign room_tail = e_cap - e_tail;
   assign room_live = e_cap - live;
   assign live_amt  = live + e_amt;
   assign head_add  = e_head + e_amt;
   assign tail_add  = e_tail + e_amt;
   assign drained   = (head_add == e_tail);

   assign grow_cap  = round_gran(max_e(max_e(e_cap + (e_cap >> 1), e_min), live_amt));
   assign grow_over = grow_cap > MAX_E;
   assign open_cap  = round_gran(e_init);
   assign open_over = open_cap > MAX_E;

   // watermark = (15 * watermark + peak + 15) / 16
   assign samp_sum = {e_wm, {AVG_SHIFT{1'b0}}} - {{AVG_SHIFT{1'b0}}, e_wm}
                   + {{AVG_SHIFT{1'b0}}, e_peak} + AW'((1 << AVG_SHIFT) - 1);
   assign wm_samp  = samp_sum[AW-1:AVG_SHIFT];

   // shrink check shared by drain and decay
   assign shr_wm   = (mode == MODE_CONSUME) ? wm_samp : (e_wm >> 1);
   assign shr_live = (mode == MODE_CONSUME) ? '0 : live;
   assign shr_tgt  = round_gran(max_e(max_e(e_min, shr_live), shr_wm));
   assign shr_ok   = (e_cap > e_min) && ((e_cap >> 1) > shr_wm) && (shr_tgt < e_cap);

   always_comb begin
      cap_in     = e_cap;
      head_in    = e_head;
      tail_in    = e_tail;
      peak_in    = e_peak;
      wm_in      = e_wm;
      traffic_in = traffic_ff;
      act_in     = ACT_NONE;
      moved_in   = '0;
      rej_in     = 1'b0;
      case (mode)
         MODE_PREPARE: begin
            if (room_tail < e_amt) begin
               if (room_live >= e_amt) begin
                  head_in  = '0;
                  tail_in  = live;
                  wm_in    = wm_samp;
                  peak_in  = live_amt;
                  act_in   = ACT_COMPACT;
                  moved_in = live;
               end else if (grow_over) begin
                  rej_in = 1'b1;
               end else begin
                  cap_in   = grow_cap;
                  head_in  = '0;
                  tail_in  = live;
                  wm_in    = grow_cap;
                  peak_in  = live_amt;
                  act_in   = ACT_GROW;
                  moved_in = live;
               end
            end else begin
               peak_in = max_e(e_peak, live_amt);
            end
         end
         MODE_COMMIT: begin
            if (e_amt > room_tail) begin
               rej_in = 1'b1;
            end else begin
               tail_in    = tail_add;
               peak_in    = max_e(e_peak, tail_add - e_head);
               traffic_in = 1'b1;
            end
         end
         MODE_CONSUME: begin
            if (e_amt > live) begin
               rej_in = 1'b1;
            end else if (drained) begin
               head_in = '0;
               tail_in = '0;
               wm_in   = wm_samp;
               peak_in = '0;
               if (shr_ok) begin
                  cap_in = shr_tgt;
                  act_in = ACT_SHRINK;
               end
            end else begin
               head_in = head_add;
            end
         end
         MODE_DECAY: begin
            if (e_cap <= e_min) begin
               cap_in = e_cap;
            end else if (traffic_ff) begin
               traffic_in = 1'b0;
            end else if ((live << 1) <= e_cap) begin
               wm_in = e_wm >> 1;
               if (shr_ok) begin
                  cap_in   = shr_tgt;
                  head_in  = '0;
                  tail_in  = live;
                  act_in   = ACT_SHRINK;
                  moved_in = live;
               end
            end
         end
         MODE_CLEAR: begin
            head_in = '0;
            tail_in = '0;
            peak_in = '0;
         end
         MODE_RESET: begin
            cap_in  = '0;
            head_in = '0;
            tail_in = '0;
            peak_in = '0;
            wm_in   = '0;
         end
         MODE_OPEN: begin
            if (open_over) begin
               rej_in = 1'b1;
            end else begin
               cap_in     = open_cap;
               head_in    = '0;
               tail_in    = '0;
               peak_in    = '0;
               wm_in      = open_cap;
               traffic_in = 1'b0;
               act_in     = (open_cap != '0) ? ACT_GROW : ACT_NONE;
            end
         end
         default: begin
            rej_in = 1'b1;
         end
      endcase
   end

   assign free_in = cap_in - tail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cap_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         peak_ff      <= '0;
         wm_ff        <= '0;
         traffic_ff   <= 1'b0;
         min_cap_ff   <= MIN_CAP_RESET;
         init_cap_ff  <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            cap_ff       <= cap_in[SW-1:0];
            head_ff      <= head_in[SW-1:0];
            tail_ff      <= tail_in[SW-1:0];
            peak_ff      <= peak_in[SW-1:0];
            wm_ff        <= wm_in[SW-1:0];
            traffic_ff   <= traffic_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == CSR_MIN_CAPACITY) begin
               min_cap_ff <= csr_data;
            end else begin
               init_cap_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mode_ff   <= req_tdata[MODE_W-1:0];
         in_amount_ff <= req_tdata[MODE_W+FIELD_W-1:MODE_W];
      end
      if (advance) begin
         out_data_ff <= {moved_in[FIELD_W-1:0], act_in, wm_in[FIELD_W-1:0],
                         free_in[FIELD_W-1:0], tail_in[FIELD_W-1:0],
                         head_in[FIELD_W-1:0], cap_in[FIELD_W-1:0]};
         out_rej_ff  <= rej_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/rbs_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module rbs_checker
   import rbs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]            rsp_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready
);

   logic [FIELD_W-1:0]  r_cap, r_write, r_free, r_moved;
   logic [ACTION_W-1:0] r_act;

   assign r_cap   = rsp_tdata[RSP_CAP_LSB +: FIELD_W];
   assign r_write = rsp_tdata[RSP_WRITE_LSB +: FIELD_W];
   assign r_free  = rsp_tdata[RSP_FREE_LSB +: FIELD_W];
   assign r_moved = rsp_tdata[RSP_MOVED_LSB +: FIELD_W];
   assign r_act   = rsp_tdata[RSP_ACT_LSB +: ACTION_W];

   `RBS_ASSERT(a_free_span, clock, reset, rsp_tvalid |-> (r_free == FIELD_W'(r_cap - r_write)), "writable bytes disagree with capacity and write offset")
   `RBS_ASSERT(a_reject_no_action, clock, reset, (rsp_tvalid && rsp_tuser[0]) |-> (r_act == ACT_NONE && r_moved == '0), "rejected item reports a copy action")
   `RBS_ASSERT(a_none_no_move, clock, reset, (rsp_tvalid && r_act == ACT_NONE) |-> (r_moved == '0), "bytes moved without a copy action")
   `RBS_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled result item changed")
   `RBS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind receive_buffer_sizing_policy rbs_checker u_rbs_checker (.*);

`default_nettype wire

@@ sim/receive_buffer_sizing_policy_tb.sv @@
`timescale 1ns / 100ps

module receive_buffer_sizing_policy_tb;
   import rbs_pkg::*;

   localparam int unsigned CYCLE_LIMIT       = 400000;
   localparam int unsigned SINK_HOLD_CYCLES  = 200;
   localparam int unsigned SETTLE_CYCLES     = 4;
   localparam int unsigned GRANULE           = 1 << GRAN_BITS;
   localparam int unsigned AVG_WEIGHT        = (1 << AVG_SHIFT) - 1;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam logic [FIELD_W-1:0] AMOUNT_ALL_ONES = '1;
   localparam logic [FIELD_W-1:0] CAP_LIMIT  = FIELD_W'(RBS_MAX_CAPACITY);

   typedef struct {
      logic [FIELD_W-1:0] capacity;
      logic [FIELD_W-1:0] read_offset;
      logic [FIELD_W-1:0] write_offset;
      logic [FIELD_W-1:0] writable_bytes;
      logic [FIELD_W-1:0] usage_mark;
      action_type         copy_action;
      logic [FIELD_W-1:0] moved_bytes;
      logic               rejected;
   } status_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = 1'b0;
   logic [FIELD_W-1:0]    csr_data = '0;

   // predicted buffer bookkeeping
   logic [FIELD_W-1:0] min_cap_cfg = MIN_CAP_RESET;
   logic [FIELD_W-1:0] init_cap_cfg = '0;
   logic [FIELD_W-1:0] alloc_size = '0;
   logic [FIELD_W-1:0] rd_cursor = '0;
   logic [FIELD_W-1:0] wr_cursor = '0;
   logic [FIELD_W-1:0] peak_fill = '0;
   logic [FIELD_W-1:0] fill_mark = '0;
   logic               saw_traffic = 1'b0;
   action_type         action_taken = ACT_NONE;
   logic [FIELD_W-1:0] bytes_moved = '0;

   status_report_type pending_reports[$];

   logic        steady_flow = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned reports_checked = 0;
   int unsigned long_holds = 0;
   int unsigned events_by_mode[8];
   int unsigned actions_seen[4];
   int unsigned refusals = 0;

   receive_buffer_sizing_policy dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned round_to_granule(int unsigned n);
      return ((n + GRANULE - 1) >> GRAN_BITS) << GRAN_BITS;
   endfunction

   // blend peak demand into the watermark, then restart the peak
   function automatic void fold_usage();
      int unsigned blend;
      blend = AVG_WEIGHT * fill_mark + peak_fill + AVG_WEIGHT;
      fill_mark = FIELD_W'(blend >> AVG_SHIFT);
      peak_fill = wr_cursor - rd_cursor;
   endfunction

   function automatic void try_shrink();
      int unsigned live;
      int unsigned target;
      if (alloc_size <= min_cap_cfg || (alloc_size >> 1) <= fill_mark) return;
      live = wr_cursor - rd_cursor;
      target = min_cap_cfg;
      if (target < live) target = live;
      if (target < fill_mark) target = fill_mark;
      target = round_to_granule(target);
      if (target < alloc_size) begin
         alloc_size = FIELD_W'(target);
         rd_cursor = '0;
         wr_cursor = FIELD_W'(live);
         action_taken = ACT_SHRINK;
         bytes_moved = FIELD_W'(live);
      end
   endfunction

   function automatic logic reserve_space(int unsigned want);
      int unsigned live;
      int unsigned grown;
      live = wr_cursor - rd_cursor;
      if (alloc_size - wr_cursor < want) begin
         if (alloc_size - live >= want) begin
            rd_cursor = '0;
            wr_cursor = FIELD_W'(live);
            action_taken = ACT_COMPACT;
            bytes_moved = FIELD_W'(live);
            fold_usage();
         end else begin
            grown = alloc_size + (alloc_size >> 1);
            if (grown < min_cap_cfg) grown = min_cap_cfg;
            if (grown < live + want) grown = live + want;
            grown = round_to_granule(grown);
            if (grown > RBS_MAX_CAPACITY) return 1'b0;
            alloc_size = FIELD_W'(grown);
            rd_cursor = '0;
            wr_cursor = FIELD_W'(live);
            fill_mark = FIELD_W'(grown);
            peak_fill = FIELD_W'(live);
            action_taken = ACT_GROW;
            bytes_moved = FIELD_W'(live);
         end
      end
      live = wr_cursor - rd_cursor;
      if (peak_fill < live + want) peak_fill = FIELD_W'(live + want);
      return 1'b1;
   endfunction

   function automatic status_report_type apply_event(logic [MODE_W-1:0] mode_bits,
                                                     logic [FIELD_W-1:0] amount);
      status_report_type rpt;
      logic accepted;
      int unsigned want;
      accepted = 1'b1;
      action_taken = ACT_NONE;
      bytes_moved = '0;
      case (mode_bits)
         MODE_PREPARE: accepted = reserve_space(amount);
         MODE_COMMIT: begin
            if (amount > alloc_size - wr_cursor) begin
               accepted = 1'b0;
            end else begin
               wr_cursor = wr_cursor + amount;
               if (peak_fill < wr_cursor - rd_cursor) peak_fill = wr_cursor - rd_cursor;
               saw_traffic = 1'b1;
            end
         end
         MODE_CONSUME: begin
            if (amount > wr_cursor - rd_cursor) begin
               accepted = 1'b0;
            end else begin
               rd_cursor = rd_cursor + amount;
               if (rd_cursor == wr_cursor) begin
                  rd_cursor = '0;
                  wr_cursor = '0;
                  fold_usage();
                  try_shrink();
               end
            end
         end
         MODE_DECAY: begin
            if (alloc_size > min_cap_cfg) begin
               if (saw_traffic) begin
                  saw_traffic = 1'b0;
               end else if (2 * (wr_cursor - rd_cursor) <= alloc_size) begin
                  fill_mark = fill_mark >> 1;
                  try_shrink();
               end
            end
         end
         MODE_CLEAR: begin
            rd_cursor = '0;
            wr_cursor = '0;
            peak_fill = '0;
         end
         MODE_RESET: begin
            alloc_size = '0;
            rd_cursor = '0;
            wr_cursor = '0;
            peak_fill = '0;
            fill_mark = '0;
         end
         MODE_OPEN: begin
            want = round_to_granule(init_cap_cfg);
            if (want > RBS_MAX_CAPACITY) begin
               accepted = 1'b0;
            end else begin
               alloc_size = FIELD_W'(want);
               rd_cursor = '0;
               wr_cursor = '0;
               peak_fill = '0;
               fill_mark = FIELD_W'(want);
               saw_traffic = 1'b0;
               if (want != 0) action_taken = ACT_GROW;
            end
         end
         default: accepted = 1'b0;
      endcase
      if (!accepted) begin
         action_taken = ACT_NONE;
         bytes_moved = '0;
      end
      rpt.capacity = alloc_size;
      rpt.read_offset = rd_cursor;
      rpt.write_offset = wr_cursor;
      rpt.writable_bytes = alloc_size - wr_cursor;
      rpt.usage_mark = fill_mark;
      rpt.copy_action = action_taken;
      rpt.moved_bytes = bytes_moved;
      rpt.rejected = !accepted;
      return rpt;
   endfunction

   function automatic void compare_field(string name, int unsigned expected_value,
                                         int unsigned actual_value);
      if (expected_value != actual_value) begin
         $error("%s: expected %0d, got %0d", name, expected_value, actual_value);
         error_count++;
      end
   endfunction

   // accepted events feed the predictor
   always @(posedge clock) begin : event_monitor
      status_report_type rpt;
      if (!reset && req_tvalid && req_tready) begin
         rpt = apply_event(req_tdata[MODE_W-1:0], req_tdata[MODE_W +: FIELD_W]);
         pending_reports.push_back(rpt);
         events_by_mode[req_tdata[MODE_W-1:0]]++;
         actions_seen[rpt.copy_action]++;
         if (rpt.rejected) refusals++;
      end
   end

   always @(posedge clock) begin : report_checker
      status_report_type rpt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("result item with no event waiting for it");
            error_count++;
         end else begin
            rpt = pending_reports.pop_front();
            reports_checked++;
            compare_field("capacity", rpt.capacity, rsp_tdata[RSP_CAP_LSB +: FIELD_W]);
            compare_field("read_offset", rpt.read_offset,
                          rsp_tdata[RSP_READ_LSB +: FIELD_W]);
            compare_field("write_offset", rpt.write_offset,
                          rsp_tdata[RSP_WRITE_LSB +: FIELD_W]);
            compare_field("writable_bytes", rpt.writable_bytes,
                          rsp_tdata[RSP_FREE_LSB +: FIELD_W]);
            compare_field("usage_mark", rpt.usage_mark, rsp_tdata[RSP_MARK_LSB +: FIELD_W]);
            compare_field("copy_action", rpt.copy_action,
                          rsp_tdata[RSP_ACT_LSB +: ACTION_W]);
            compare_field("moved_bytes", rpt.moved_bytes,
                          rsp_tdata[RSP_MOVED_LSB +: FIELD_W]);
            compare_field("rejected", rpt.rejected, rsp_tuser[0]);
         end
      end
   end

   // result side: random stalls, steady stretches and requested long holds
   initial begin : result_sink
      int unsigned span;
      @(negedge clock);
      forever begin
         if (long_holds < hold_requests) begin
            rsp_tready <= 1'b0;
            for (span = 0; span < SINK_HOLD_CYCLES; span++) @(negedge clock);
            long_holds++;
         end else if (steady_flow || $urandom_range(0, 9) != 0) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            span = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
            repeat (span) @(negedge clock);
         end
      end
   end

   task automatic send_event(logic [MODE_W-1:0] mode_bits, logic [FIELD_W-1:0] amount);
      int unsigned gap;
      int unsigned pick;
      gap = 0;
      if (!steady_flow) begin
         pick = $urandom_range(0, 99);
         if (pick >= 97) gap = $urandom_range(15, 50);
         else if (pick >= 88) gap = $urandom_range(4, 10);
         else if (pick >= 60) gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - MODE_W - FIELD_W){1'b0}}, amount, mode_bits};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_all_reported();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic reg_index, logic [FIELD_W-1:0] value);
      wait_all_reported();
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (reg_index == CSR_MIN_CAPACITY) min_cap_cfg = value;
      else init_cap_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed prepare/commit/consume cycles, plus decay, clear, reset, open and some noise
   task automatic run_buffer_traffic(int unsigned count);
      int unsigned pick;
      int unsigned live;
      int unsigned room;
      int unsigned sel;
      logic [FIELD_W-1:0] amt;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         sel = $urandom_range(0, 19);
         live = wr_cursor - rd_cursor;
         room = alloc_size - wr_cursor;
         if (pick < 28) begin
            if (sel == 0) amt = FIELD_W'($urandom_range(0, AMOUNT_ALL_ONES));
            else if (sel < 4) amt = FIELD_W'($urandom_range(0, 1 << 20));
            else amt = FIELD_W'($urandom_range(0, 6000));
            send_event(MODE_PREPARE, amt);
         end else if (pick < 52) begin
            if (sel < 2) amt = FIELD_W'(room + $urandom_range(1, 4096));
            else if (sel < 6) amt = FIELD_W'(room);
            else amt = FIELD_W'($urandom_range(0, room));
            send_event(MODE_COMMIT, amt);
         end else if (pick < 76) begin
            if (sel < 2) amt = FIELD_W'(live + $urandom_range(1, 4096));
            else if (sel < 10) amt = FIELD_W'(live);
            else amt = FIELD_W'($urandom_range(0, live));
            send_event(MODE_CONSUME, amt);
         end else if (pick < 88) begin
            send_event(MODE_DECAY, FIELD_W'($urandom_range(0, AMOUNT_ALL_ONES)));
         end else if (pick < 92) begin
            send_event(MODE_CLEAR, FIELD_W'($urandom_range(0, AMOUNT_ALL_ONES)));
         end else if (pick < 94) begin
            send_event(MODE_RESET, FIELD_W'($urandom_range(0, AMOUNT_ALL_ONES)));
         end else if (pick < 97) begin
            send_event(MODE_OPEN, FIELD_W'($urandom_range(0, AMOUNT_ALL_ONES)));
         end else begin
            send_event(MODE_W'($urandom_range(0, 7)),
                       FIELD_W'($urandom_range(0, AMOUNT_ALL_ONES)));
         end
      end
   endtask

   task automatic test_directed_events();
      send_event(MODE_OPEN, '0);
      send_event(MODE_COMMIT, 25'd1);
      send_event(MODE_CONSUME, 25'd1);
      send_event(MODE_CONSUME, '0);
      send_event(MODE_PREPARE, 25'd100);
      send_event(MODE_COMMIT, 25'd100);
      send_event(MODE_CONSUME, 25'd40);
      send_event(MODE_PREPARE, 25'd4000);
      send_event(MODE_PREPARE, AMOUNT_ALL_ONES);
      send_event(MODE_PREPARE, 25'd10000);
      send_event(MODE_COMMIT, 25'd5000);
      send_event(MODE_CONSUME, wr_cursor - rd_cursor);
      send_event(MODE_DECAY, '0);
      send_event(MODE_DECAY, '0);
      send_event(MODE_DECAY, AMOUNT_ALL_ONES);
      send_event(MODE_CLEAR, '0);
      send_event(MODE_UNUSED, AMOUNT_ALL_ONES);
      send_event(MODE_RESET, '0);
      send_event(MODE_PREPARE, CAP_LIMIT);
      send_event(MODE_COMMIT, CAP_LIMIT);
      send_event(MODE_DECAY, '0);
      send_event(MODE_DECAY, '0);
      send_event(MODE_CONSUME, CAP_LIMIT);
      send_event(MODE_OPEN, '0);
   endtask

   task automatic test_register_sweep();
      write_register(CSR_MIN_CAPACITY, 25'd256);
      write_register(CSR_INITIAL_CAPACITY, CAP_LIMIT);
      send_event(MODE_OPEN, '0);
      run_buffer_traffic(70);
      write_register(CSR_MIN_CAPACITY, CAP_LIMIT);
      write_register(CSR_INITIAL_CAPACITY, '0);
      send_event(MODE_OPEN, '0);
      run_buffer_traffic(40);
      write_register(CSR_INITIAL_CAPACITY, AMOUNT_ALL_ONES);
      send_event(MODE_OPEN, '0);
      send_event(MODE_PREPARE, 25'd1);
      write_register(CSR_INITIAL_CAPACITY, CAP_LIMIT - 25'd1);
      send_event(MODE_OPEN, '0);
      run_buffer_traffic(10);
      write_register(CSR_MIN_CAPACITY, FIELD_W'($urandom_range(256, 65536)));
      write_register(CSR_INITIAL_CAPACITY, FIELD_W'($urandom_range(0, 200000)));
      send_event(MODE_OPEN, '0);
      run_buffer_traffic(100);
   endtask

   // long output hold while events keep coming, then drain fully
   task automatic test_input_backpressure();
      wait_all_reported();
      steady_flow = 1'b1;
      hold_requests++;
      run_buffer_traffic(24);
      wait_all_reported();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_traffic();
      int unsigned chunk;
      write_register(CSR_MIN_CAPACITY, MIN_CAP_RESET);
      write_register(CSR_INITIAL_CAPACITY, 25'd8192);
      for (chunk = 0; chunk < 6; chunk++) begin
         steady_flow = chunk[0];
         run_buffer_traffic(25);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_directed_events();
      test_register_sweep();
      test_input_backpressure();
      test_random_traffic();
      wait_all_reported();
      repeat (8) @(posedge clock);
      $display("events: %0d prepare, %0d commit, %0d consume, %0d decay, %0d clear/reset/open,",
               events_by_mode[MODE_PREPARE], events_by_mode[MODE_COMMIT],
               events_by_mode[MODE_CONSUME], events_by_mode[MODE_DECAY],
               events_by_mode[MODE_CLEAR] + events_by_mode[MODE_RESET]
               + events_by_mode[MODE_OPEN]);
      $display("%0d unused; %0d compact, %0d grow, %0d shrink, %0d refused, %0d held, %0d checked",
               events_by_mode[MODE_UNUSED], actions_seen[ACT_COMPACT], actions_seen[ACT_GROW],
               actions_seen[ACT_SHRINK], refusals, long_holds, reports_checked);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
